// File: hdl/fft_window_coefficient_macros.svh
// Assertion macros for the window coefficient generator.
`ifndef FFT_WINDOW_COEFFICIENT_MACROS_SVH
`define FFT_WINDOW_COEFFICIENT_MACROS_SVH
`ifndef SYNTHESIS
`define FWC_ASSERT_IMPLY(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define FWC_ASSERT_DELAY(lbl, clk, rst, a, n, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##(n) (b)) else $error(msg);
`else
`define FWC_ASSERT_IMPLY(lbl, clk, rst, a, b, msg)
`define FWC_ASSERT_DELAY(lbl, clk, rst, a, n, b, msg)
`endif
`endif

// File: hdl/fwc_pkg.sv
// Shared types, constants and tables of the window coefficient generator.
`timescale 1ns / 1ps
package fwc_pkg;
   localparam int IDX_W          = 12;
   localparam int LEN_W          = 13;
   localparam int TYPE_W         = 2;
   localparam int COEF_W         = 18;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_MAX_LENGTH = 4096;
   localparam int DEF_PHASE_BITS = 16;
   localparam int CORDIC_STEPS   = 28;
   localparam int ANG_W          = 32;
   localparam int XY_W           = 32;
   localparam int Z_W            = 33;
   localparam int PROD_W         = 64;

   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
   localparam logic [30:0] W_054 = 31'd579820585;
   localparam logic [30:0] W_046 = 31'd493921239;
   localparam logic [30:0] W_050 = 31'd536870912;
   localparam logic [30:0] W_042 = 31'd450971566;
   localparam logic [30:0] W_008 = 31'd85899346;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sd131071;
   localparam logic signed [COEF_W-1:0] COEF_MIN = -18'sd131072;

   typedef enum logic [TYPE_W-1:0] {
      WIN_RECT     = 2'd0,
      WIN_HAMMING  = 2'd1,
      WIN_HANN     = 2'd2,
      WIN_BLACKMAN = 2'd3
   } win_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_TYPE   = 2'd0,
      CSR_WINDOW_LENGTH = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic valid;
      logic err;
      logic bypass;
      logic neg1;
      logic neg2;
   } tag_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } lane_type;

   // atan(2^-step) in turns scaled by 2^32
   function automatic logic [31:0] atan_turn(input int step);
      logic [31:0] v;
      unique case (step)
         0: v = 32'd536870912;   1: v = 32'd316933406;  2: v = 32'd167458907;
         3: v = 32'd85004756;    4: v = 32'd42667331;   5: v = 32'd21354465;
         6: v = 32'd10679838;    7: v = 32'd5340245;    8: v = 32'd2670163;
         9: v = 32'd1335087;    10: v = 32'd667544;    11: v = 32'd333772;
        12: v = 32'd166886;     13: v = 32'd83443;     14: v = 32'd41722;
        15: v = 32'd20861;      16: v = 32'd10430;     17: v = 32'd5215;
        18: v = 32'd2608;       19: v = 32'd1304;      20: v = 32'd652;
        21: v = 32'd326;        22: v = 32'd163;       23: v = 32'd81;
        24: v = 32'd41;         25: v = 32'd20;        26: v = 32'd10;
        27: v = 32'd5;
        default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage

// File: hdl/fwc_div_cell.sv
// One quotient bit of the pipelined phase divider.
`timescale 1ns / 1ps
module fwc_div_cell import fwc_pkg::*; #(
   parameter int NUM_W = 29,
   parameter int QUO_W = 17,
   parameter int BIT   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [LEN_W-1:0] den,
   input  logic [NUM_W-1:0] rem_i,
   input  logic [QUO_W-1:0] quo_i,
   input  tag_type          tag_i,
   output logic [NUM_W-1:0] rem_o,
   output logic [QUO_W-1:0] quo_o,
   output tag_type          tag_o
);
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   tag_type          tag_ff;
   logic [NUM_W-1:0] shifted;

   always_comb begin
      shifted = NUM_W'(den) << BIT;
      rem_in  = rem_i;
      quo_in  = quo_i;
      if (rem_i >= shifted) begin
         rem_in      = rem_i - shifted;
         quo_in[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_i;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign tag_o = tag_ff;
endmodule

// File: hdl/fwc_cordic_cell.sv
// One rotation step of the dual-lane cosine CORDIC.
`timescale 1ns / 1ps
module fwc_cordic_cell import fwc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  lane_type lane1_i,
   input  lane_type lane2_i,
   input  tag_type  tag_i,
   output lane_type lane1_o,
   output lane_type lane2_o,
   output tag_type  tag_o
);
   localparam logic signed [Z_W-1:0] DZ = $signed({1'b0, atan_turn(STEP)});

   lane_type lane1_ff, lane1_in, lane2_ff, lane2_in;
   tag_type  tag_ff;

   function automatic lane_type rotate(input lane_type l);
      logic signed [XY_W-1:0] x, y, dx, dy;
      logic signed [Z_W-1:0]  z;
      lane_type r;
      x  = l.x;
      y  = l.y;
      z  = l.z;
      dx = y >>> STEP;
      dy = x >>> STEP;
      if (!z[Z_W-1]) begin
         r.x = x - dx;
         r.y = y + dy;
         r.z = z - DZ;
      end else begin
         r.x = x + dx;
         r.y = y - dy;
         r.z = z + DZ;
      end
      return r;
   endfunction

   always_comb begin
      lane1_in = rotate(lane1_i);
      lane2_in = rotate(lane2_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_i;
      end
      lane1_ff <= lane1_in;
      lane2_ff <= lane2_in;
   end

   assign lane1_o = lane1_ff;
   assign lane2_o = lane2_ff;
   assign tag_o   = tag_ff;
endmodule

// File: hdl/fwc_mix.sv
// Window weighting: sign fix, constant products, rounding and saturation.
`timescale 1ns / 1ps
module fwc_mix import fwc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  win_kind_type             kind,
   input  logic signed [XY_W-1:0]   x1,
   input  logic signed [XY_W-1:0]   x2,
   input  tag_type                  tag_i,
   output logic                     strobe,
   output logic signed [COEF_W-1:0] coefficient,
   output logic                     index_error
);
   localparam logic signed [PROD_W-1:0] ROUND = 64'sd1 <<< 43;
   localparam int Q_W = PROD_W - 44;

   // stage A: apply the fold sign
   logic signed [XY_W-1:0] c1_ff, c1_in, c2_ff, c2_in;
   tag_type                tag_a_ff;
   // stage B: products
   logic signed [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in, k0_ff, k0_in;
   tag_type                  tag_b_ff;
   // stage C: output
   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic                     err_ff, err_in, strobe_ff;
   logic signed [PROD_W-1:0] sum;
   logic signed [Q_W-1:0]    q;
   logic [30:0]              k1;

   always_comb begin
      c1_in = tag_i.neg1 ? -x1 : x1;
      c2_in = tag_i.neg2 ? -x2 : x2;
   end

   always_comb begin
      unique case (kind)
         WIN_HAMMING: begin
            k1    = W_046;
            k0_in = $signed(PROD_W'(W_054) << 30);
         end
         WIN_BLACKMAN: begin
            k1    = W_050;
            k0_in = $signed(PROD_W'(W_042) << 30);
         end
         default: begin
            k1    = W_050;
            k0_in = $signed(PROD_W'(W_050) << 30);
         end
      endcase
      p1_in = PROD_W'($signed({1'b0, k1}) * c1_a());
      p2_in = (kind == WIN_BLACKMAN) ? PROD_W'($signed({1'b0, W_008}) * c2_ff) : '0;
   end

   function automatic logic signed [XY_W-1:0] c1_a();
      return c1_ff;
   endfunction

   always_comb begin
      sum = k0_ff - p1_ff + p2_ff + ROUND;
      q   = sum[PROD_W-1:44];
      if (q > Q_W'(COEF_MAX)) begin
         coef_in = COEF_MAX;
      end else if (q < Q_W'(COEF_MIN)) begin
         coef_in = COEF_MIN;
      end else begin
         coef_in = q[COEF_W-1:0];
      end
      err_in = 1'b0;
      if (tag_b_ff.err) begin
         coef_in = '0;
         err_in  = tag_b_ff.valid;
      end else if (tag_b_ff.bypass) begin
         coef_in = COEF_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff  <= '0;
         tag_b_ff  <= '0;
         strobe_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         tag_a_ff  <= tag_i;
         tag_b_ff  <= tag_a_ff;
         strobe_ff <= tag_b_ff.valid;
         err_ff    <= err_in;
      end
      c1_ff   <= c1_in;
      c2_ff   <= c2_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      k0_ff   <= k0_in;
      coef_ff <= coef_in;
   end

   assign strobe      = strobe_ff;
   assign coefficient = coef_ff;
   assign index_error = err_ff;
endmodule

// File: hdl/fft_window_coefficient.sv
// Top level of the FFT window coefficient generator.
`timescale 1ns / 1ps
`include "fft_window_coefficient_macros.svh"
// Window coefficient generator: one sample index per clock in, one
// coefficient per index out. busy stays low, so a new index can be
// started every cycle; each index passes through the divider cells (one
// per quotient bit, PHASE_BITS + 1), the 28 CORDIC cells and the three
// weighting stages. The receiver cannot stall: each word sits on the
// rsp_ ports for exactly one cycle with rsp_strobe high and must be
// taken then. Write the csr_ registers only while no index is in flight.
module fft_window_coefficient import fwc_pkg::*; #(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH,
   parameter int PHASE_BITS = DEF_PHASE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start,
   input  logic [IDX_W-1:0]         req_sample_index,
   output logic                     busy,
   output logic                     rsp_strobe,
   output logic signed [COEF_W-1:0] rsp_coefficient,
   output logic                     rsp_index_error,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [LEN_W-1:0]         csr_data
);
   localparam int NUM_W     = IDX_W + PHASE_BITS + 1;
   localparam int QUO_W     = PHASE_BITS + 1;
   localparam int DIV_CELLS = PHASE_BITS + 1;
   localparam int MIX_LAT   = 3;
   localparam int LEN_MAXV  = (MAX_LENGTH > 8191) ? 8191 : MAX_LENGTH;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(LEN_MAXV);

   // configuration registers
   win_kind_type     window_type_ff, window_type_in;
   logic [LEN_W-1:0] window_length_ff, window_length_in;

   always_comb begin
      window_type_in   = window_type_ff;
      window_length_in = window_length_ff;
      if (csr_write_enable) begin
         unique case (csr_reg_type'(csr_index))
            CSR_WINDOW_TYPE:   window_type_in   = win_kind_type'(csr_data[TYPE_W-1:0]);
            CSR_WINDOW_LENGTH: window_length_in = csr_data;
            default: ;   // drop writes to unknown registers
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_type_ff   <= WIN_RECT;
         window_length_ff <= LEN_RESET;
      end else begin
         window_type_ff   <= window_type_in;
         window_length_ff <= window_length_in;
      end
   end

   // clamp the length and derive the divisor
   logic [LEN_W-1:0] len_eff, den;
   logic             accept;
   tag_type          tag_in;
   logic [NUM_W-1:0] num_in;

   always_comb begin
      len_eff = (window_length_ff > LEN_RESET) ? LEN_RESET : window_length_ff;
      den     = len_eff - 1'b1;
      accept  = req_start && !busy;
      tag_in.valid  = accept;
      tag_in.err    = {1'b0, req_sample_index} >= len_eff;
      tag_in.bypass = (len_eff == LEN_W'(1)) || (window_type_ff == WIN_RECT);
      tag_in.neg1   = 1'b0;
      tag_in.neg2   = 1'b0;
      // round to nearest: add half the divisor before dividing
      num_in = ({NUM_W'(req_sample_index)} << PHASE_BITS) + NUM_W'(den >> 1);
   end

   assign busy = 1'b0;

   // divider chain, one quotient bit per cell, MSB first
   logic [NUM_W-1:0] rem_w [DIV_CELLS+1];
   logic [QUO_W-1:0] quo_w [DIV_CELLS+1];
   tag_type          dtag_w [DIV_CELLS+1];

   assign rem_w[0]  = num_in;
   assign quo_w[0]  = '0;
   assign dtag_w[0] = tag_in;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      fwc_div_cell #(
         .NUM_W (NUM_W),
         .QUO_W (QUO_W),
         .BIT   (PHASE_BITS - i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .den   (den),
         .rem_i (rem_w[i]),
         .quo_i (quo_w[i]),
         .tag_i (dtag_w[i]),
         .rem_o (rem_w[i+1]),
         .quo_o (quo_w[i+1]),
         .tag_o (dtag_w[i+1])
      );
   end

   // widen the phase to a turn fraction and fold into the right half plane
   logic [ANG_W-1:0] ang1, ang2, fold1, fold2, t1, t2;
   lane_type         lane1_w [CORDIC_STEPS+1];
   lane_type         lane2_w [CORDIC_STEPS+1];
   tag_type          ctag_w  [CORDIC_STEPS+1];

   always_comb begin
      ang1  = {quo_w[DIV_CELLS][PHASE_BITS-1:0], {(ANG_W-PHASE_BITS){1'b0}}};
      ang2  = ang1 << 1;
      t1    = ang1 + 32'h4000_0000;
      t2    = ang2 + 32'h4000_0000;
      fold1 = t1[ANG_W-1] ? ang1 + 32'h8000_0000 : ang1;
      fold2 = t2[ANG_W-1] ? ang2 + 32'h8000_0000 : ang2;
      lane1_w[0].x = $signed(CORDIC_GAIN);
      lane1_w[0].y = '0;
      lane1_w[0].z = $signed({fold1[ANG_W-1], fold1});
      lane2_w[0].x = $signed(CORDIC_GAIN);
      lane2_w[0].y = '0;
      lane2_w[0].z = $signed({fold2[ANG_W-1], fold2});
      ctag_w[0]      = dtag_w[DIV_CELLS];
      ctag_w[0].neg1 = t1[ANG_W-1];
      ctag_w[0].neg2 = t2[ANG_W-1];
   end

   // CORDIC chain, both lanes advance one step per cell
   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
      fwc_cordic_cell #(
         .STEP (s)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .lane1_i (lane1_w[s]),
         .lane2_i (lane2_w[s]),
         .tag_i   (ctag_w[s]),
         .lane1_o (lane1_w[s+1]),
         .lane2_o (lane2_w[s+1]),
         .tag_o   (ctag_w[s+1])
      );
   end

   // weight, round and saturate
   fwc_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .kind        (window_type_ff),
      .x1          (lane1_w[CORDIC_STEPS].x),
      .x2          (lane2_w[CORDIC_STEPS].x),
      .tag_i       (ctag_w[CORDIC_STEPS]),
      .strobe      (rsp_strobe),
      .coefficient (rsp_coefficient),
      .index_error (rsp_index_error)
   );

   // an index error always carries a zero coefficient
   `FWC_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_index_error, rsp_strobe && rsp_coefficient == '0, "index error without zero coefficient")
   // a word leaving the CORDIC chain shows up on the result port
   `FWC_ASSERT_DELAY(a_mix_lat, clock, reset, ctag_w[CORDIC_STEPS].valid, MIX_LAT, rsp_strobe, "word lost in weighting stages")
   // an out-of-range index leaving the divider ends as an error word
   `FWC_ASSERT_DELAY(a_err_path, clock, reset, dtag_w[DIV_CELLS].valid && dtag_w[DIV_CELLS].err, CORDIC_STEPS + MIX_LAT, rsp_index_error, "index error flag dropped")
endmodule

// File: tb/fft_window_coefficient_test.sv
// Self-checking testbench for the FFT window coefficient generator.
`timescale 1ns / 1ps
module fft_window_coefficient_test;
   import fwc_pkg::*;

   // Register indexes that the block has no register for; writes there are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int DRAIN_CYCLES = DEF_PHASE_BITS + 32 + 16;

   typedef struct {
      logic signed [COEF_W-1:0] coef;
      logic                     err;
   } window_word_type;

   logic                     clock;
   logic                     reset;
   logic                     req_start;
   logic [IDX_W-1:0]         req_sample_index;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [COEF_W-1:0] rsp_coefficient;
   logic                     rsp_index_error;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [LEN_W-1:0]         csr_data;

   // Shadow copy of the block's registers.
   win_kind_type     shadow_kind;
   logic [LEN_W-1:0] shadow_length;

   window_word_type pending_coefs[$];
   int mismatches;
   int words_sent;
   int words_checked;
   int index_errors_seen;

   fft_window_coefficient dut (
      .clock            (clock),
      .reset            (reset),
      .req_start        (req_start),
      .req_sample_index (req_sample_index),
      .busy             (busy),
      .rsp_strobe       (rsp_strobe),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_index_error  (rsp_index_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cosine of a 32-bit turn fraction in Q30, by a 28-step CORDIC after
   // folding the angle into the right half plane.
   function automatic longint cordic_cos(input logic [31:0] turn);
      logic [31:0] a;
      logic        flip;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      a = turn;
      flip = 1'b0;
      x = longint'(CORDIC_GAIN);
      y = 0;
      if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
         flip = 1'b1;
         a = a + 32'h8000_0000;
      end
      z = longint'($signed(a));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(atan_turn(i));
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(atan_turn(i));
         end
      end
      return flip ? -x : x;
   endfunction

   // Expected word for one sample index under the shadow registers.
   function automatic window_word_type window_value(input logic [IDX_W-1:0] sample);
      window_word_type w;
      longint      eff_len;
      longint      den;
      longint      phase;
      logic [31:0] turn;
      longint      c1;
      longint      c2;
      longint      acc;
      longint      q16;
      eff_len = (shadow_length > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : longint'(shadow_length);
      w.err = 1'b0;
      if (longint'(sample) >= eff_len) begin
         w.coef = '0;
         w.err = 1'b1;
         return w;
      end
      if (eff_len == 1 || shadow_kind == WIN_RECT) begin
         w.coef = COEF_ONE;
         return w;
      end
      den = eff_len - 1;
      phase = ((longint'(sample) << DEF_PHASE_BITS) + den / 2) / den;
      turn = 32'(phase & ((64'd1 << DEF_PHASE_BITS) - 1)) << (32 - DEF_PHASE_BITS);
      c1 = cordic_cos(turn);
      case (shadow_kind)
         WIN_HAMMING: begin
            acc = longint'(W_054) * (64'sd1 <<< 30) - longint'(W_046) * c1;
         end
         WIN_HANN: begin
            acc = longint'(W_050) * (64'sd1 <<< 30) - longint'(W_050) * c1;
         end
         default: begin
            c2 = cordic_cos(turn * 2);
            acc = longint'(W_042) * (64'sd1 <<< 30) - longint'(W_050) * c1
                  + longint'(W_008) * c2;
         end
      endcase
      q16 = (acc + (64'sd1 <<< 43)) >>> 44;
      if (q16 > longint'(COEF_MAX)) q16 = longint'(COEF_MAX);
      if (q16 < longint'(COEF_MIN)) q16 = longint'(COEF_MIN);
      w.coef = q16[COEF_W-1:0];
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Compare each result word against the oldest pending expectation.
   // Sample at the falling edge, halfway between driving edges.
   always @(negedge clock) begin
      window_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_coefs.size() == 0) begin
            report_mismatch($sformatf("unexpected word coef=%0d err=%0b",
                                      rsp_coefficient, rsp_index_error));
         end else begin
            want = pending_coefs.pop_front();
            words_checked++;
            if (rsp_index_error) index_errors_seen++;
            if (rsp_coefficient !== want.coef)
               report_mismatch($sformatf("coefficient %0d, expected %0d",
                                         rsp_coefficient, want.coef));
            if (rsp_index_error !== want.err)
               report_mismatch($sformatf("index_error %0b, expected %0b",
                                         rsp_index_error, want.err));
         end
      end
   end

   // Present one index and hold it until the block takes it. Leaves req_start
   // high, so a following send continues the burst without a gap.
   task automatic send_index(input logic [IDX_W-1:0] sample);
      req_start <= 1'b1;
      req_sample_index <= sample;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_coefs.push_back(window_value(sample));
      words_sent++;
   endtask

   task automatic idle_cycles(input int n);
      req_start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop start, wait for every pending word, then let the pipeline settle.
   task automatic drain;
      idle_cycles(1);
      while (pending_coefs.size() != 0) @(negedge clock);
      @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller drops it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      if (idx == CSR_WINDOW_TYPE) shadow_kind = win_kind_type'(data[TYPE_W-1:0]);
      else if (idx == CSR_WINDOW_LENGTH) shadow_length = data;
   endtask

   task automatic configure(input win_kind_type kind, input logic [LEN_W-1:0] len);
      drain();
      write_csr(CSR_WINDOW_TYPE, LEN_W'(kind));
      write_csr(CSR_WINDOW_LENGTH, len);
      csr_write_enable <= 1'b0;
   endtask

   // Defaults after reset: rectangular over the longest window.
   task automatic test_reset_defaults;
      send_index('0);
      send_index(12'd2048);
      send_index(12'hFFF);
   endtask

   // Each non-rectangular window shape on a short window: ends, middle and just past the end.
   task automatic test_window_shapes;
      for (int k = 1; k < 4; k++) begin
         configure(win_kind_type'(k), 13'd9);
         send_index(12'd0);
         send_index(12'd4);
         send_index(12'd8);
         send_index(12'd9);
      end
   endtask

   // Length guards: one sample, zero length, oversized length, two samples.
   task automatic test_length_guards;
      configure(WIN_BLACKMAN, 13'd1);
      send_index(12'd0);
      send_index(12'd1);
      configure(WIN_HANN, 13'd0);
      send_index(12'd0);
      configure(WIN_HAMMING, 13'h1FFF);
      send_index(12'hFFF);
      send_index(12'h555);
      configure(WIN_HANN, 13'd2);
      send_index(12'd1);
      send_index(12'd2);
   endtask

   // Writes to the unused register indexes must change nothing.
   task automatic test_spare_registers;
      configure(WIN_HAMMING, 13'd100);
      write_csr(CSR_SPARE_A, 13'h1FFF);
      write_csr(CSR_SPARE_B, 13'd0);
      csr_write_enable <= 1'b0;
      send_index(12'd50);
      send_index(12'd99);
   endtask

   // Random bursts over a series of settings; indexes mostly inside the window.
   task automatic test_random_traffic;
      logic [LEN_W-1:0] lengths[10] = '{13'd4096, 13'd2, 13'd1, 13'd37, 13'd4095,
                                        13'h1FFF, 13'd256, 13'd1000, 13'd0, 13'd3};
      int               eff;
      int               left;
      int               burst;
      logic [IDX_W-1:0] sample;
      for (int p = 0; p < 10; p++) begin
         configure(win_kind_type'($urandom_range(3, 0)), lengths[p]);
         if (p == 0) configure(WIN_BLACKMAN, 13'd4096);
         eff = (lengths[p] > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : int'(lengths[p]);
         left = 170;
         while (left > 0) begin
            burst = $urandom_range(40, 1);
            for (int b = 0; b < burst && left > 0; b++, left--) begin
               if (eff == 0 || $urandom_range(9, 0) == 0) sample = IDX_W'($urandom);
               else sample = IDX_W'($urandom_range(eff - 1, 0));
               send_index(sample);
            end
            // Every other phase runs without gaps for a stretch.
            if (p % 2 == 0 || $urandom_range(3, 0) == 0) idle_cycles($urandom_range(6, 1));
            // Midway through one phase, hold off until the pipeline is empty.
            if (p == 4 && left < 90 && left > 50) drain();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_start <= 1'b0;
      req_sample_index <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_WINDOW_TYPE;
      csr_data <= '0;
      shadow_kind = WIN_RECT;
      shadow_length = LEN_W'(DEF_MAX_LENGTH);
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      index_errors_seen = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_window_shapes();
      test_length_guards();
      test_spare_registers();
      test_random_traffic();
      drain();

      $display("Covered %0d indexes over all four window shapes and lengths 0 to 8191;",
               words_sent);
      $display("checked %0d words, %0d of them out-of-range indexes.",
               words_checked, index_errors_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d words pending", pending_coefs.size());
      $display("simulation failed");
      $finish;
   end
endmodule
